FILE: hw/rtl/array_linked_list_engine_assert.svh
// Assertion macros shared by the linked-list engine RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define LLE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LLE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lle_pkg.sv
// Shared types and codes for the linked-list engine.
// No dependencies; imported by the engine top level.
package lle_pkg;

   // request operation codes
   typedef enum logic [2:0] {
      KIND_PUSH_HEAD  = 3'd0,
      KIND_PUSH_TAIL  = 3'd1,
      KIND_INS_AFTER  = 3'd2,
      KIND_INS_BEFORE = 3'd3,
      KIND_POP_HEAD   = 3'd4,
      KIND_POP_TAIL   = 3'd5,
      KIND_REM_AFTER  = 3'd6,
      KIND_REM_BEFORE = 3'd7
   } kind_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD1  = 5'b00010,
      S_RD2  = 5'b00100,
      S_WR   = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

endpackage

FILE: hw/rtl/array_linked_list_engine.sv
// Doubly linked list kept in a store of CAPACITY entries (entry 0 is the sentinel), with
// unused entries chained on a free list. One request at a time: a successful push, insert,
// pop or remove reads the position entry, then the allocated or removed entry, then makes
// two rounds of writes before the response register; a failing one responds after the
// first read. Entries never yet allocated are tracked by a fill mark, so no clearing pass
// runs after reset. Depends on lle_pkg, lle_ram and array_linked_list_engine_assert.svh.
module array_linked_list_engine
   import lle_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_entry_index,
   output logic signed [31:0] rsp_removed_value,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

   // control state
   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] free_ff, free_in, count_ff, count_in;
   logic [IW:0]   fill_ff, fill_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // request and operation payload
   kind_type              kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic                  range_bad_ff, range_bad_in;
   logic [IW-1:0]         a_ff, a_in, b_ff, b_in, e_ff, e_in;
   logic [IW-1:0]         res_idx_ff, res_idx_in;
   logic [31:0]           res_data_ff, res_data_in;
   status_type            res_status_ff, res_status_in;
   logic [IW-1:0]         rsp_idx_ff, rsp_idx_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [IW-1:0]         rsp_count_ff, rsp_count_in;

   // memory ports
   logic [IW-1:0]         rd_addr;
   logic                  nx_we, pv_we, dt_we, us_we;
   logic [IW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd;
   logic [DATA_WIDTH-1:0] dt_q;
   logic [IW-1:0]         nx_q, pv_q;
   logic                  us_wd, us_q;

   // decode helpers
   logic          accept, uses_pos, is_ins, is_after;
   kind_type      req_kind_t;
   logic [IW-1:0] req_pos_idx, succ_p, pred_p, victim, next_free;
   logic          p_bad;

   lle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(rd_addr), .rd_data(nx_q));

   lle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr(rd_addr), .rd_data(pv_q));

   lle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data (
      .clock(clock), .wr_en(dt_we), .wr_addr(e_ff), .wr_data(value_ff),
      .rd_addr(rd_addr), .rd_data(dt_q));

   lle_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used (
      .clock(clock), .wr_en(us_we), .wr_addr(e_ff), .wr_data(us_wd),
      .rd_addr(rd_addr), .rd_data(us_q));

   // request decode
   always_comb begin
      req_kind_t  = kind_type'(req_kind);
      accept      = req_valid && !req_stall;
      uses_pos    = req_kind_t inside {KIND_INS_AFTER, KIND_INS_BEFORE,
                                       KIND_REM_AFTER, KIND_REM_BEFORE};
      req_pos_idx = uses_pos ? IW'(req_position) : '0;
      is_ins      = kind_ff inside {KIND_PUSH_HEAD, KIND_PUSH_TAIL,
                                    KIND_INS_AFTER, KIND_INS_BEFORE};
      is_after    = kind_ff inside {KIND_PUSH_HEAD, KIND_INS_AFTER,
                                    KIND_POP_HEAD, KIND_REM_AFTER};
   end

   // neighbors of the position entry; untouched entries read as not in use
   always_comb begin
      p_bad  = range_bad_ff ||
               ((pos_ff != '0) && (({1'b0, pos_ff} >= fill_ff) || !us_q));
      succ_p = (pos_ff == '0) ? head_ff : nx_q;
      pred_p = (pos_ff == '0) ? tail_ff : pv_q;
      victim = is_after ? succ_p : pred_p;
      // free-list successor: never-allocated entries chain to the following one
      if ({1'b0, e_ff} >= fill_ff) begin
         next_free = (e_ff == LAST) ? '0 : e_ff + 1'b1;
      end else begin
         next_free = nx_q;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      kind_in       = kind_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      range_bad_in  = range_bad_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      res_idx_in    = res_idx_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = req_pos_idx;
      nx_we = 1'b0; nx_wa = a_ff; nx_wd = b_ff;
      pv_we = 1'b0; pv_wa = b_ff; pv_wd = a_ff;
      dt_we = 1'b0;
      us_we = 1'b0; us_wd = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in      = req_kind_t;
               value_in     = DATA_WIDTH'(req_value);
               pos_in       = req_pos_idx;
               range_bad_in = uses_pos && (32'(req_position) >= CAPACITY);
               state_in     = S_RD1;
            end
         end
         // position entry read back: check and locate the target entry
         S_RD1: begin
            res_idx_in  = '0;
            res_data_in = '0;
            rd_addr     = is_ins ? free_ff : victim;
            if (p_bad) begin
               res_status_in = ST_BADPOS;
               state_in      = S_RESP;
            end else if (is_ins) begin
               if (free_ff == '0) begin
                  res_status_in = ST_FULL;
                  state_in      = S_RESP;
               end else begin
                  a_in     = is_after ? pos_ff : pred_p;
                  b_in     = is_after ? succ_p : pos_ff;
                  e_in     = free_ff;
                  state_in = S_RD2;
               end
            end else if (victim == '0) begin
               res_status_in = ST_EMPTY;
               state_in      = S_RESP;
            end else begin
               e_in     = victim;
               state_in = S_RD2;
            end
         end
         // target entry read back: first round of writes
         S_RD2: begin
            res_idx_in    = e_ff;
            res_status_in = ST_OK;
            state_in      = S_WR;
            if (is_ins) begin
               nx_we = 1'b1; nx_wa = e_ff; nx_wd = b_ff;
               pv_we = 1'b1; pv_wa = e_ff; pv_wd = a_ff;
               dt_we = 1'b1;
               us_we = 1'b1; us_wd = 1'b1;
               free_in  = next_free;
               count_in = count_ff + 1'b1;
               if ({1'b0, e_ff} == fill_ff) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else begin
               a_in        = pv_q;
               b_in        = nx_q;
               res_data_in = 32'($signed(dt_q));
               count_in    = count_ff - 1'b1;
               nx_wa = pv_q; nx_wd = nx_q;
               pv_wa = nx_q; pv_wd = pv_q;
               if (pv_q != '0) nx_we = 1'b1; else head_in = nx_q;
               if (nx_q != '0) pv_we = 1'b1; else tail_in = pv_q;
            end
         end
         // second round of writes
         S_WR: begin
            state_in = S_RESP;
            if (is_ins) begin
               nx_wa = a_ff; nx_wd = e_ff;
               pv_wa = b_ff; pv_wd = e_ff;
               if (a_ff != '0) nx_we = 1'b1; else head_in = e_ff;
               if (b_ff != '0) pv_we = 1'b1; else tail_in = e_ff;
            end else begin
               nx_we = 1'b1; nx_wa = e_ff; nx_wd = free_ff;
               pv_we = 1'b1; pv_wa = e_ff; pv_wd = '0;
               us_we = 1'b1; us_wd = 1'b0;
               free_in = e_ff;
            end
         end
         // hand the response to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= IW'(1);
         count_ff     <= '0;
         fill_ff      <= (IW+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      range_bad_ff  <= range_bad_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      res_idx_ff    <= res_idx_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_index   = 6'(rsp_idx_ff);
   assign rsp_removed_value = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = 6'(rsp_count_ff);

`include "array_linked_list_engine_assert.svh"

   `LLE_ASSERT_ALWAYS(a_count_range, clock, reset, ({1'b0, count_ff} < (IW+1)'(CAPACITY)), "list count beyond capacity")
   `LLE_ASSERT_ALWAYS(a_fill_range, clock, reset, ({1'b0, fill_ff} <= (IW+2)'(CAPACITY)), "fill mark beyond capacity")
   `LLE_ASSERT_IMPLY(a_free_full, clock, reset, (state_ff == S_IDLE), ((free_ff == '0) == (count_ff == LAST)), "free list and count disagree")
   `LLE_ASSERT_IMPLY(a_ok_index, clock, reset, (rsp_valid_ff && (rsp_status_ff == ST_OK)), (rsp_idx_ff != '0), "ok response names the sentinel")
   `LLE_ASSERT_NEXT(a_ins_count, clock, reset, ((state_ff == S_RD2) && is_ins), (count_ff == $past(count_ff) + 1'b1), "insert did not grow the list")

endmodule

FILE: hw/rtl/lle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for every link and data store of the engine.
module lle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
